[hdl/sfh_pkg.sv]
package sfh_pkg;

    // Field widths
    localparam int LEN_W    = 16;
    localparam int HASH_W   = 32;
    localparam int BUCKET_W = 16;
    localparam int BYTE_W   = 8;

    // Significant bits of the stated length (16 or more keeps all 16 bits)
    localparam int LENGTH_BITS = 16;
    localparam logic [LEN_W-1:0] LEN_MASK =
        (LENGTH_BITS >= LEN_W) ? {LEN_W{1'b1}} : LEN_W'((64'd1 << LENGTH_BITS) - 64'd1);

    localparam logic [BUCKET_W-1:0] BUCKET_RESET = BUCKET_W'(256);

    // Avalanche runs two operations per cycle
    localparam int AVAL_STEPS = 3;
    localparam int AVAL_W     = $clog2(AVAL_STEPS);

    // Restoring divider, one quotient bit per cycle
    localparam int DIV_STEPS = HASH_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic              byte_en;   // take one accepted byte
        logic              tail_en;   // fold leftover bytes, clear name state
        logic              aval_en;   // one avalanche step
        logic [AVAL_W-1:0] aval_step;
        logic              div_start; // load dividend and divisor
        logic              div_en;    // one divider iteration
        logic              out_load;  // move result into output register
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
    } t_dp_sts;

endpackage

[hdl/sfh_if.sv]
interface sfh_in_if;
    import sfh_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              first_byte;
    logic              last_byte;
    logic [LEN_W-1:0]  message_length;

    modport source (output valid, output data_byte, output first_byte,
                    output last_byte, output message_length, input ready);
    modport sink   (input valid, input data_byte, input first_byte,
                    input last_byte, input message_length, output ready);
endinterface

interface sfh_out_if;
    import sfh_pkg::*;
    logic                valid;
    logic                ready;
    logic [HASH_W-1:0]   hash_value;
    logic [BUCKET_W-1:0] bucket_index;

    modport source (output valid, output hash_value, output bucket_index, input ready);
    modport sink   (input valid, input hash_value, input bucket_index, output ready);
endinterface

[hdl/sfh_dp.sv]
module sfh_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  sfh_pkg::t_dp_cmd          i_cmd,
    output sfh_pkg::t_dp_sts          o_sts,
    input  logic [sfh_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic                      i_first_byte,
    input  logic [sfh_pkg::LEN_W-1:0]    i_message_length,
    input  logic                      i_cfg_wr_en,
    input  logic [sfh_pkg::BUCKET_W-1:0] i_cfg_wr_data,
    output logic [sfh_pkg::HASH_W-1:0]   o_hash_value,
    output logic [sfh_pkg::BUCKET_W-1:0] o_bucket_index
);
    import sfh_pkg::*;

    function automatic logic [HASH_W-1:0] sext8(input logic [BYTE_W-1:0] b);
        return {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
    endfunction

    function automatic logic [HASH_W-1:0] mix_group(input logic [HASH_W-1:0] h_in,
                                                    input logic [15:0] w0,
                                                    input logic [15:0] w1);
        logic [HASH_W-1:0] h;
        logic [HASH_W-1:0] t;
        h = h_in + HASH_W'(w0);
        t = (HASH_W'(w1) << 11) ^ h;
        h = (h << 16) ^ t;
        h = h + (h >> 11);
        return h;
    endfunction

    function automatic logic [HASH_W-1:0] fold_tail(input logic [HASH_W-1:0] h_in,
                                                    input logic [23:0] held,
                                                    input logic [1:0] cnt);
        logic [HASH_W-1:0] h;
        h = h_in;
        case (cnt)
            2'd3: begin
                h = h + HASH_W'(held[15:0]);
                h = h ^ (h << 16);
                h = h ^ (sext8(held[23:16]) << 18);
                h = h + (h >> 11);
            end
            2'd2: begin
                h = h + HASH_W'(held[15:0]);
                h = h ^ (h << 11);
                h = h + (h >> 17);
            end
            2'd1: begin
                h = h + sext8(held[7:0]);
                h = h ^ (h << 10);
                h = h + (h >> 1);
            end
            default: h = h_in;
        endcase
        return h;
    endfunction

    function automatic logic [HASH_W-1:0] aval(input logic [HASH_W-1:0] h_in,
                                               input logic [AVAL_W-1:0] step);
        logic [HASH_W-1:0] h;
        h = h_in;
        case (step)
            AVAL_W'(0): begin
                h = h ^ (h << 3);
                h = h + (h >> 5);
            end
            AVAL_W'(1): begin
                h = h ^ (h << 4);
                h = h + (h >> 17);
            end
            default: begin
                h = h ^ (h << 25);
                h = h + (h >> 6);
            end
        endcase
        return h;
    endfunction

    logic [HASH_W-1:0]    r_acc, n_acc;
    logic [23:0]          r_pend, n_pend;
    logic [1:0]           r_cnt, n_cnt;
    logic                 r_empty, n_empty;
    logic [HASH_W-1:0]    r_h;
    logic [HASH_W-1:0]    r_dvd;
    logic [BUCKET_W-1:0]  r_rem;
    logic [BUCKET_W-1:0]  r_dvs;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [BUCKET_W-1:0]  r_bucket;
    logic [HASH_W-1:0]    r_out_hash;
    logic [BUCKET_W-1:0]  r_out_bucket;

    logic [HASH_W-1:0]   base_acc;
    logic [23:0]         base_pend;
    logic [1:0]          base_cnt;
    logic                base_empty;
    logic [LEN_W-1:0]    len_m;
    logic [HASH_W-1:0]   h_aval;
    logic [BUCKET_W:0]   rem_sh;
    logic [BUCKET_W:0]   rem_diff;

    // Byte intake: reseed on a first mark, then hold or mix
    always_comb begin
        len_m      = i_message_length & LEN_MASK;
        base_acc   = i_first_byte ? HASH_W'(len_m) : r_acc;
        base_pend  = i_first_byte ? 24'd0 : r_pend;
        base_cnt   = i_first_byte ? 2'd0 : r_cnt;
        base_empty = i_first_byte ? (len_m == '0) : r_empty;
        n_acc      = base_acc;
        n_pend     = base_pend;
        n_cnt      = base_cnt;
        n_empty    = base_empty;
        if (!base_empty) begin
            if (base_cnt == 2'd3) begin
                n_acc  = mix_group(base_acc, base_pend[15:0], {i_data_byte, base_pend[23:16]});
                n_pend = 24'd0;
                n_cnt  = 2'd0;
            end else begin
                case (base_cnt)
                    2'd0:    n_pend[7:0]   = i_data_byte;
                    2'd1:    n_pend[15:8]  = i_data_byte;
                    default: n_pend[23:16] = i_data_byte;
                endcase
                n_cnt = base_cnt + 2'd1;
            end
        end
    end

    assign h_aval   = aval(r_h, i_cmd.aval_step);
    assign rem_sh   = {r_rem, r_dvd[HASH_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_dvs};

    assign o_sts.div_done = i_cmd.div_en && (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_pend   <= '0;
            r_cnt    <= '0;
            r_empty  <= 1'b0;
            r_bucket <= BUCKET_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_bucket <= i_cfg_wr_data;
            end
            if (i_cmd.byte_en) begin
                r_acc   <= n_acc;
                r_pend  <= n_pend;
                r_cnt   <= n_cnt;
                r_empty <= n_empty;
            end else if (i_cmd.tail_en) begin
                r_acc   <= '0;
                r_pend  <= '0;
                r_cnt   <= '0;
                r_empty <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tail_en) begin
            r_h <= r_empty ? '0 : fold_tail(r_acc, r_pend, r_cnt);
        end else if (i_cmd.aval_en) begin
            r_h <= h_aval;
        end
        if (i_cmd.div_start) begin
            r_dvd     <= h_aval;
            r_dvs     <= r_bucket;
            r_rem     <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_en) begin
            r_dvd     <= {r_dvd[HASH_W-2:0], 1'b0};
            r_rem     <= rem_diff[BUCKET_W] ? rem_sh[BUCKET_W-1:0] : rem_diff[BUCKET_W-1:0];
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end
        if (i_cmd.out_load) begin
            r_out_hash   <= r_h;
            r_out_bucket <= (r_dvs == '0) ? '0 : r_rem;
        end
    end

    assign o_hash_value   = r_out_hash;
    assign o_bucket_index = r_out_bucket;

endmodule

[hdl/sfh_ctrl.sv]
module sfh_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output sfh_pkg::t_dp_cmd o_cmd,
    input  sfh_pkg::t_dp_sts i_sts
);
    import sfh_pkg::*;

    localparam logic [2:0] ST_BYTE = 3'd0;
    localparam logic [2:0] ST_TAIL = 3'd1;
    localparam logic [2:0] ST_AVAL = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_LOAD = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [AVAL_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              in_acc;
    logic              aval_last;

    assign o_in_ready = (r_state == ST_BYTE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign aval_last  = (r_step == AVAL_W'(AVAL_STEPS - 1));

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.aval_step = r_step;
        unique case (r_state)
            ST_BYTE: begin
                o_cmd.byte_en = in_acc;
                if (in_acc && i_in_last) begin
                    n_state = ST_TAIL;
                end
            end
            ST_TAIL: begin
                o_cmd.tail_en = 1'b1;
                n_step        = '0;
                n_state       = ST_AVAL;
            end
            ST_AVAL: begin
                o_cmd.aval_en = 1'b1;
                n_step        = r_step + AVAL_W'(1);
                if (aval_last) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_en = 1'b1;
                if (i_sts.div_done) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_BYTE;
                end
            end
            default: n_state = ST_BYTE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_BYTE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_last_to_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_last) |=> (r_state == ST_TAIL))
        else $error("last byte did not start the tail fold");
    a_aval_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_AVAL && aval_last) |=> (r_state == ST_DIV))
        else $error("divider not started after avalanche");
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == ST_DIV))
        else $error("divider done outside divide state");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD && r_out_valid && !i_out_ready) |=>
            (r_state == ST_LOAD && r_out_valid))
        else $error("pending result overwritten");
`endif

endmodule

[hdl/superfasthash_bucket_index.sv]
// Channel   Dir  Payload                                             Notes
// i_in      in   data_byte, first_byte, last_byte, message_length   one byte per transaction
// o_out     out  hash_value, bucket_index                            one per name
// cfg       in   i_cfg_wr_data (bucket_count)                        write on i_cfg_wr_en
//
// Sequence: after the last byte of a name no byte is taken until the block has run
//   the tail fold, 3 avalanche steps, 32 divider iterations and the result load.
//   The restoring divider (one remainder bit per cycle) sets the per-name overhead.
// Reset: synchronous, active low; bucket_count returns to 256, hash state clears.
// Stalls: a finished result waits in the output register while bytes of the next
//   name are taken; only the load of the following result waits on o_out.ready.
module superfasthash_bucket_index (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    sfh_in_if.sink                       i_in,
    sfh_out_if.source                    o_out,
    input  logic                         i_cfg_wr_en,
    input  logic [sfh_pkg::BUCKET_W-1:0] i_cfg_wr_data
);
    import sfh_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer: byte intake, tail, avalanche, divide, result load
    sfh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_last   (i_in.last_byte),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // Hash state, avalanche, bucket divider and output registers
    sfh_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_data_byte      (i_in.data_byte),
        .i_first_byte     (i_in.first_byte),
        .i_message_length (i_in.message_length),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .o_hash_value     (o_out.hash_value),
        .o_bucket_index   (o_out.bucket_index)
    );

endmodule

[tb/tb.sv]
module tb;
    import sfh_pkg::*;

    // Clock, reset and configuration port
    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_wr_en;
    logic [BUCKET_W-1:0] i_cfg_wr_data;

    sfh_in_if  in_if ();
    sfh_out_if out_if ();

    superfasthash_bucket_index u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_if),
        .o_out         (out_if),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // Quiet cycles after the last expected hash before the block is driven again
    localparam int SETTLE_CYCLES = 48;

    typedef struct {
        bit [HASH_W-1:0]   hash;
        bit [BUCKET_W-1:0] bucket;
    } t_name_hash;

    // Predicted results, oldest first
    t_name_hash name_hashes[$];

    // Shadow of the block's hashing state and bucket register
    bit [HASH_W-1:0]   acc;
    bit [23:0]         held;
    bit [1:0]          held_cnt;
    bit                empty_name;
    bit [BUCKET_W-1:0] bucket_cnt;

    bit calm;        // no idling on either side while set
    int err_cnt;
    int sent_items;

    // 20-unit clock period
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // One full group of four bytes, taken as two little-endian 16-bit words
    function automatic bit [31:0] mix_word_pair(bit [31:0] h, bit [15:0] w0, bit [15:0] w1);
        bit [31:0] t;
        h = h + {16'h0, w0};
        t = ({16'h0, w1} << 11) ^ h;
        h = (h << 16) ^ t;
        h = h + (h >> 11);
        return h;
    endfunction

    // Leftover bytes (odd byte sign-extended), then the avalanche
    function automatic bit [31:0] finalize_hash(bit [31:0] h, bit [23:0] b, bit [1:0] cnt);
        case (cnt)
            2'd3: begin
                h = h + {16'h0, b[15:0]};
                h = h ^ (h << 16);
                h = h ^ ({{24{b[23]}}, b[23:16]} << 18);
                h = h + (h >> 11);
            end
            2'd2: begin
                h = h + {16'h0, b[15:0]};
                h = h ^ (h << 11);
                h = h + (h >> 17);
            end
            2'd1: begin
                h = h + {{24{b[7]}}, b[7:0]};
                h = h ^ (h << 10);
                h = h + (h >> 1);
            end
            default: ;
        endcase
        h = h ^ (h << 3);
        h = h + (h >> 5);
        h = h ^ (h << 4);
        h = h + (h >> 17);
        h = h ^ (h << 25);
        h = h + (h >> 6);
        return h;
    endfunction

    // Update the shadow state with one accepted byte; queue a hash on the last mark
    task automatic absorb_byte(bit [7:0] b, bit f, bit l, bit [15:0] len);
        t_name_hash res;
        bit [15:0]  stated;
        stated = len & LEN_MASK;
        if (f) begin
            acc        = {16'h0, stated};
            held       = '0;
            held_cnt   = '0;
            empty_name = (stated == '0);
        end
        if (!empty_name) begin
            if (held_cnt == 2'd3) begin
                acc      = mix_word_pair(acc, held[15:0], {b, held[23:16]});
                held     = '0;
                held_cnt = '0;
            end else begin
                held[8*held_cnt +: 8] = b;
                held_cnt = held_cnt + 2'd1;
            end
        end
        if (l) begin
            res.hash   = empty_name ? '0 : finalize_hash(acc, held, held_cnt);
            res.bucket = (bucket_cnt == '0) ? '0 : BUCKET_W'(res.hash % {16'h0, bucket_cnt});
            name_hashes.push_back(res);
            acc        = '0;
            held       = '0;
            held_cnt   = '0;
            empty_name = 1'b0;
        end
    endtask

    // Present one byte transaction; called and returns at a falling edge.
    // valid stays high on return so back-to-back bytes need no reassertion.
    task automatic send_item(bit [7:0] b, bit f, bit l, bit [15:0] len);
        while (!calm && $urandom_range(99) < 9) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid          <= 1'b1;
        in_if.data_byte      <= b;
        in_if.first_byte     <= f;
        in_if.last_byte      <= l;
        in_if.message_length <= len;
        do @(posedge i_clk); while (!in_if.ready);
        absorb_byte(b, f, l, len);
        sent_items++;
        @(negedge i_clk);
    endtask

    // n random bytes; marked puts the first mark on byte 0, closed the last mark
    task automatic send_name(int n, bit [15:0] stated, bit marked, bit closed);
        for (int i = 0; i < n; i++)
            send_item(8'($urandom), marked && (i == 0), closed && (i == n - 1), stated);
    endtask

    // Stop sending and let every predicted hash come out, then let the block settle
    task automatic wait_drain();
        in_if.valid <= 1'b0;
        while (name_hashes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // bucket_count is only rewritten with the block idle
    task automatic write_bucket_count(bit [15:0] v);
        wait_drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        bucket_cnt = v;
    endtask

    task automatic flag_error(string msg);
        if (err_cnt < 10) $display("%s", msg);
        err_cnt++;
    endtask

    // Receiver stalls at random, never while calm
    always @(negedge i_clk) begin
        if (i_rst_n) out_if.ready <= calm || ($urandom_range(99) >= 9);
    end

    // Every result transaction against the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_name_hash want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (name_hashes.size() == 0) begin
                flag_error($sformatf("unexpected result: hash %h bucket %0d",
                                     out_if.hash_value, out_if.bucket_index));
            end else begin
                want = name_hashes.pop_front();
                if (out_if.hash_value !== want.hash)
                    flag_error($sformatf("hash_value mismatch: expected %h got %h",
                                         want.hash, out_if.hash_value));
                if (out_if.bucket_index !== want.bucket)
                    flag_error($sformatf("bucket_index mismatch: expected %0d got %0d (hash %h)",
                                         want.bucket, out_if.bucket_index, want.hash));
            end
        end
    end

    // Extremes and every corner of the name framing, default bucket count
    task automatic test_directed_names();
        // no first mark right after reset: seed is 0
        send_item(8'h12, 1'b0, 1'b0, 16'h0);
        send_item(8'h34, 1'b0, 1'b1, 16'h0);
        // empty name in one transaction, then with ignored bytes
        send_item(8'h00, 1'b1, 1'b1, 16'h0);
        send_item(8'hFF, 1'b1, 1'b0, 16'h0);
        send_item(8'hAA, 1'b0, 1'b0, 16'h0);
        send_item(8'h55, 1'b0, 1'b1, 16'h0);
        // one, two and three leftover bytes, with sign-extended odd bytes
        send_item(8'h80, 1'b1, 1'b1, 16'd1);
        send_item(8'hFF, 1'b1, 1'b0, 16'd2);
        send_item(8'h7F, 1'b0, 1'b1, 16'd2);
        send_item(8'h01, 1'b1, 1'b0, 16'd3);
        send_item(8'h02, 1'b0, 1'b0, 16'd3);
        send_item(8'h80, 1'b0, 1'b1, 16'd3);
        // one full group, stated length at its maximum
        send_item(8'hFF, 1'b1, 1'b0, 16'hFFFF);
        send_item(8'hFF, 1'b0, 1'b0, 16'hFFFF);
        send_item(8'hFF, 1'b0, 1'b0, 16'hFFFF);
        send_item(8'hFF, 1'b0, 1'b1, 16'hFFFF);
        // group plus one, all-zero group bytes, top length bit set
        send_item(8'h00, 1'b1, 1'b0, 16'h8000);
        send_item(8'h00, 1'b0, 1'b0, 16'h8000);
        send_item(8'h00, 1'b0, 1'b0, 16'h8000);
        send_item(8'h00, 1'b0, 1'b0, 16'h8000);
        send_item(8'hFE, 1'b0, 1'b1, 16'h8000);
        // restart in the middle of a name drops the partial hash
        send_item(8'hAB, 1'b1, 1'b0, 16'd7);
        send_item(8'hCD, 1'b0, 1'b0, 16'd7);
        send_item(8'h11, 1'b1, 1'b0, 16'd2);
        send_item(8'h22, 1'b0, 1'b1, 16'd2);
    endtask

    // Smallest, largest and zero bucket counts, plus 2 and 255
    task automatic test_bucket_extremes();
        bit [15:0] counts[5] = '{16'd1, 16'hFFFF, 16'd0, 16'd2, 16'd255};
        int        n;
        foreach (counts[k]) begin
            write_bucket_count(counts[k]);
            for (int j = 0; j < 3; j++) begin
                n = $urandom_range(1, 9);
                send_name(n, 16'(n), 1'b1, 1'b1);
            end
        end
    endtask

    // Mostly well-formed names with random content; the rest noise and broken names
    task automatic test_random_names();
        int start;
        int since_cfg;
        int pick;
        int n;
        start     = sent_items;
        since_cfg = 0;
        while (sent_items < start + 650) begin
            // long stretch with no idling on either side
            calm = (sent_items - start >= 200) && (sent_items - start < 380);
            if (sent_items - start - since_cfg >= 150) begin
                since_cfg = sent_items - start;
                pick = $urandom_range(3);
                case (pick)
                    0:       write_bucket_count(16'd1);
                    1:       write_bucket_count(16'hFFFF);
                    2:       write_bucket_count(16'd0);
                    default: write_bucket_count(16'($urandom_range(1, 65535)));
                endcase
            end
            pick = $urandom_range(99);
            if (pick < 70) begin
                n = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                send_name(n, 16'(n), 1'b1, 1'b1);
            end else if (pick < 78) begin
                send_name($urandom_range(1, 4), 16'h0, 1'b1, 1'b1);
            end else if (pick < 86) begin
                // stated length disagrees with the bytes sent
                send_name($urandom_range(1, 12), 16'($urandom), 1'b1, 1'b1);
            end else if (pick < 93) begin
                send_item(8'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
            end else begin
                // name cut short; the next name restarts over it or continues it
                n = $urandom_range(1, 6);
                send_name(n, 16'(n + $urandom_range(1, 5)), 1'($urandom), 1'b0);
            end
            // sender holds off until every hash is back
            if ($urandom_range(49) == 0) wait_drain();
        end
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n              = 1'b0;
        i_cfg_wr_en          = 1'b0;
        i_cfg_wr_data        = '0;
        in_if.valid          = 1'b0;
        in_if.data_byte      = '0;
        in_if.first_byte     = 1'b0;
        in_if.last_byte      = 1'b0;
        in_if.message_length = '0;
        out_if.ready         = 1'b0;
        acc        = '0;
        held       = '0;
        held_cnt   = '0;
        empty_name = 1'b0;
        bucket_cnt = BUCKET_RESET;
        calm       = 1'b0;
        err_cnt    = 0;
        sent_items = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_names();
        test_bucket_extremes();
        test_random_names();

        wait_drain();
        if (err_cnt == 0 && name_hashes.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
hdl/sfh_pkg.sv
hdl/sfh_if.sv
hdl/sfh_dp.sv
hdl/sfh_ctrl.sv
hdl/superfasthash_bucket_index.sv
tb/tb.sv
